FILE: sv/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  // operation codes
  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_REAR  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_POP_REAR   = 2'd3
  } func_e_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  // source of the result word
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_MEM  = 2'd1,
    SEL_ONES = 2'd2
  } word_sel_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } res_t;

  // access to the ring memory
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } mem_req_t;

  // registered result fields from the controller
  typedef struct packed {
    word_sel_t  sel;
    logic [1:0] status;
    logic [4:0] occupancy;
  } ctrl_res_t;

endpackage

FILE: sv/dq_ring_mem.sv
module dq_ring_mem
  import dq_pkg::*;
(
  input  logic                  clk,
  input  mem_req_t              req,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: sv/dq_ctrl.sv
module dq_ctrl
  import dq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  cmd_t      cmd,
  output mem_req_t  req,
  output logic      done,
  output ctrl_res_t res
);

  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic             full, empty;
  logic [IDX_W-1:0] head_dec, head_inc, rear_pos, last_pos;
  logic [SUM_W-1:0] sum, sum_last;
  ctrl_res_t        res_next;

  // ring positions around the head
  always_comb begin
    full     = (count == CNT_W'(DEPTH));
    empty    = (count == '0);
    head_dec = (head == '0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
    head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
    sum      = SUM_W'(head) + SUM_W'(count);
    sum_last = sum - 1'b1;
    rear_pos = (sum >= SUM_W'(DEPTH)) ? IDX_W'(sum - SUM_W'(DEPTH)) : IDX_W'(sum);
    last_pos = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                            : IDX_W'(sum_last);
  end

  // operation decode
  always_comb begin
    head_next    = head;
    count_next   = count;
    req.we       = 1'b0;
    req.waddr    = rear_pos;
    req.wdata    = DATA_WIDTH'($unsigned(cmd.push_value));
    req.re       = 1'b0;
    req.raddr    = head;
    res_next.sel = SEL_ZERO;
    res_next.status = ST_DONE;
    unique case (cmd.func)
      FN_PUSH_FRONT, FN_PUSH_REAR: begin
        if (full) begin
          res_next.status = ST_FULL;
        end else begin
          req.we     = accept;
          count_next = count + 1'b1;
          if (cmd.func == FN_PUSH_FRONT) begin
            req.waddr = head_dec;
            head_next = head_dec;
          end
        end
      end
      FN_POP_FRONT, FN_POP_REAR: begin
        if (empty) begin
          res_next.status = ST_EMPTY;
          res_next.sel    = SEL_ONES;
        end else begin
          req.re       = accept;
          res_next.sel = SEL_MEM;
          count_next   = count - 1'b1;
          if (cmd.func == FN_POP_FRONT) begin
            head_next = head_inc;
          end else begin
            req.raddr = last_pos;
          end
        end
      end
      default: ;
    endcase
    res_next.occupancy = 5'(count_next);
  end

  // pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

  // result fields, aligned with the memory read data
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

FILE: sv/double_ended_queue_ring.sv
// Double-ended queue of signed words held in a ring memory.
// Command channel: a beat (cmd.func, cmd.push_value) is taken at a rising
// edge where start is high and busy is low. busy stays low, so a command
// may be issued in every cycle.
// func: push front, push rear, pop front, pop rear.
// Result channel: each command yields one result beat (pop_value, status,
// occupancy), shown for exactly one cycle with done high, in the cycle after
// the command beat. Throughput is one command per cycle; the result fields
// are registered to line up with the registered read port of the ring memory.
// A push to a full queue is dropped with full status; a pop from an empty
// queue gives -1 with empty status. occupancy is the count afterwards.
// Reset (rst, synchronous) empties the queue; memory contents are not
// cleared, as an entry is only read after a push has written it.
// The receiver cannot hold results off: it must take each done beat.
module double_ended_queue_ring
  import dq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  mem_req_t              req;
  logic [DATA_WIDTH-1:0] rdata;
  ctrl_res_t             cres;
  logic                  accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  dq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .req    (req),
    .done   (done),
    .res    (cres)
  );

  dq_ring_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // result word selection
  always_comb begin
    unique case (cres.sel)
      SEL_MEM:  result.pop_value = 32'($unsigned(rdata));
      SEL_ONES: result.pop_value = '1;
      default:  result.pop_value = '0;
    endcase
    result.status    = cres.status;
    result.occupancy = cres.occupancy;
  end

endmodule
